[rtl/core/assert_macros.svh]
// Assertion helper macros for the Euler rotation core.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational implication checked every clock
`define EAVR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// antecedent in this cycle, consequent in the next
`define EAVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/eavr_pkg.sv]
// Package for the Euler angle vector rotation core.
// Transaction structs, fixed widths, sine coefficients, Q30 rounding multiply.
`default_nettype none
package eavr_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int ACC_W   = 32;
    localparam int U_W     = 31;
    localparam int P_W     = ACC_W + U_W + 1;
    localparam int HORNER_STAGES = 5;

    localparam logic [U_W-1:0] Q30_ONE = U_W'(31'h4000_0000);
    localparam logic signed [ACC_W-1:0] SIN_C11 = 32'sd3864;

    localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_STAGES] = '{
        32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
    };

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } eavr_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic                      saturated;
    } eavr_out_t;

    typedef struct packed {
        logic neg;
        logic one;
        logic zero;
    } lane_flags_t;

    // a*b / 2^30, rounded half away from zero
    function automatic logic signed [ACC_W:0] mul_round30(
        input logic signed [ACC_W-1:0] a,
        input logic [U_W-1:0] b
    );
        logic signed [P_W-1:0] p;
        logic [P_W-1:0] mag;
        logic [P_W-1:0] r;
        p = P_W'(a) * P_W'($signed({1'b0, b}));
        mag = p[P_W-1] ? $unsigned(-p) : $unsigned(p);
        r = (mag + (P_W'(1) << 29)) >> 30;
        return p[P_W-1] ? -$signed(r[ACC_W:0]) : $signed(r[ACC_W:0]);
    endfunction

endpackage
`default_nettype wire

[rtl/core/euler_angle_vector_rotation_top.sv]
// Euler angle (Z-Y-X) vector rotation core, top level.
// Depends on eavr_pkg, eavr_sine_lane, eavr_dot_row and assert_macros.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry one request transaction: direction bit,
//   vector (Q15.16) and roll/pitch/yaw binary angles. m_valid/m_ready/m_data
//   return the rotated vector and a saturation flag, one per request, in order.
//   A request passes the sine lanes (front end, five Horner cells, final
//   multiply and rounding), the trig-product and matrix registers, and the
//   product and result registers of the dot-product rows before m_valid.
//   Throughput is one transaction per cycle unless the receiver stalls; the
//   pipeline advances whenever the output register is empty or being taken,
//   so s_ready = !m_valid | m_ready. On such a stall with a result held, the
//   whole pipeline freezes and s_ready drops; the held result stays stable.
//   Synchronous active-low reset clears all valid bits; payload is not reset.
//   There are no configuration registers and no state between transactions.
`default_nettype none
`include "assert_macros.svh"
module euler_angle_vector_rotation_top import eavr_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire eavr_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output eavr_out_t      m_data
);
    localparam int TFB      = TRIG_FRAC_BITS;
    localparam int TW       = TFB + 2;
    localparam int LAT      = 13;
    localparam int PAY_LAT  = 11;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;
    eavr_in_t pay_reg [PAY_LAT];

    logic [ANGLE_W-1:0]    ang [6];
    logic signed [TW-1:0]  trig [6];

    logic signed [TW-1:0] st_cps_reg, st_sps_reg, ct_cps_reg, ct_sps_reg;
    logic signed [TW-1:0] sph_ct_reg, cph_ct_reg, cph_sps_reg, cph_cps_reg;
    logic signed [TW-1:0] sph_sps_reg, sph_cps_reg, sph_reg, cph_reg, st_reg;
    logic signed [TW-1:0] m_reg [3][3];
    logic signed [TW:0]   s10, s11, s20, s21;

    logic signed [TW-1:0]      e_row [3][3];
    logic signed [COORD_W-1:0] v_in  [3];
    logic signed [COORD_W-1:0] rot   [3];
    logic [2:0]                sat;
    logic                      at_limit;

    function automatic logic signed [TW-1:0] mtrig(
        input logic signed [TW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [2*TW-1:0] p;
        logic [2*TW-1:0] mag;
        logic [2*TW-1:0] r;
        p = (2*TW)'(a) * (2*TW)'(b);
        mag = p[2*TW-1] ? $unsigned(-p) : $unsigned(p);
        r = (mag + ((2*TW)'(1) << (TFB - 1))) >> TFB;
        return p[2*TW-1] ? -$signed(r[TW-1:0]) : $signed(r[TW-1:0]);
    endfunction

    function automatic logic signed [TW-1:0] clip1(input logic signed [TW:0] x);
        logic signed [TW:0] one;
        one = (TW+1)'(1) << TFB;
        if (x > one) begin
            return TW'(one);
        end else if (x < -one) begin
            return TW'(-one);
        end
        return x[TW-1:0];
    endfunction

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0] <= s_data;
            for (int i = 1; i < PAY_LAT; i++) begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    assign ang[0] = s_data.roll;
    assign ang[1] = s_data.roll;
    assign ang[2] = s_data.pitch;
    assign ang[3] = s_data.pitch;
    assign ang[4] = s_data.yaw;
    assign ang[5] = s_data.yaw;

    for (genvar i = 0; i < 6; i++) begin : g_lane
        localparam bit LANE_COS = (i % 2) == 1;
        eavr_sine_lane #(.TFB(TFB), .IS_COS(LANE_COS)) u_lane (
            .aclk     (aclk),
            .en       (en),
            .angle    (ang[i]),
            .trig_reg (trig[i])
        );
    end

    // trig index: 0 sph, 1 cph, 2 st, 3 ct, 4 sps, 5 cps
    always_ff @(posedge aclk) begin
        if (en) begin
            st_cps_reg  <= mtrig(trig[2], trig[5]);
            st_sps_reg  <= mtrig(trig[2], trig[4]);
            ct_cps_reg  <= mtrig(trig[3], trig[5]);
            ct_sps_reg  <= mtrig(trig[3], trig[4]);
            sph_ct_reg  <= mtrig(trig[0], trig[3]);
            cph_ct_reg  <= mtrig(trig[1], trig[3]);
            cph_sps_reg <= mtrig(trig[1], trig[4]);
            cph_cps_reg <= mtrig(trig[1], trig[5]);
            sph_sps_reg <= mtrig(trig[0], trig[4]);
            sph_cps_reg <= mtrig(trig[0], trig[5]);
            sph_reg     <= trig[0];
            cph_reg     <= trig[1];
            st_reg      <= trig[2];
        end
    end

    assign s10 = (TW+1)'(mtrig(sph_reg, st_cps_reg)) - (TW+1)'(cph_sps_reg);
    assign s11 = (TW+1)'(mtrig(sph_reg, st_sps_reg)) + (TW+1)'(cph_cps_reg);
    assign s20 = (TW+1)'(mtrig(cph_reg, st_cps_reg)) + (TW+1)'(sph_sps_reg);
    assign s21 = (TW+1)'(mtrig(cph_reg, st_sps_reg)) - (TW+1)'(sph_cps_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0][0] <= ct_cps_reg;
            m_reg[0][1] <= ct_sps_reg;
            m_reg[0][2] <= -st_reg;
            m_reg[1][0] <= clip1(s10);
            m_reg[1][1] <= clip1(s11);
            m_reg[1][2] <= sph_ct_reg;
            m_reg[2][0] <= clip1(s20);
            m_reg[2][1] <= clip1(s21);
            m_reg[2][2] <= cph_ct_reg;
        end
    end

    assign v_in[0] = pay_reg[PAY_LAT-1].vec_x;
    assign v_in[1] = pay_reg[PAY_LAT-1].vec_y;
    assign v_in[2] = pay_reg[PAY_LAT-1].vec_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e_row[i][j] = pay_reg[PAY_LAT-1].req_type ? m_reg[j][i] : m_reg[i][j];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        eavr_dot_row #(.TFB(TFB)) u_row (
            .aclk    (aclk),
            .en      (en),
            .e       (e_row[i]),
            .v       (v_in),
            .rot_reg (rot[i]),
            .sat_reg (sat[i])
        );
    end

    assign m_data.rot_x     = rot[0];
    assign m_data.rot_y     = rot[1];
    assign m_data.rot_z     = rot[2];
    assign m_data.saturated = |sat;

    assign at_limit = (m_data.rot_x == COORD_MAX) || (m_data.rot_x == COORD_MIN)
                   || (m_data.rot_y == COORD_MAX) || (m_data.rot_y == COORD_MIN)
                   || (m_data.rot_z == COORD_MAX) || (m_data.rot_z == COORD_MIN);

    `EAVR_ASSERT(a_sat_at_limit, aclk, aresetn, (m_valid && m_data.saturated) |-> at_limit)
    `EAVR_ASSERT_NEXT(a_freeze_on_stall, aclk, aresetn, !s_ready, $stable(vld_reg))
    `EAVR_ASSERT_NEXT(a_advance_on_go, aclk, aresetn, s_ready && !vld_reg[LAT-2], !m_valid)
endmodule
`default_nettype wire

[rtl/core/eavr_horner_cell.sv]
// One Horner step of the quarter-wave sine polynomial: acc = coef + acc*u2.
// Depends on eavr_pkg.
`default_nettype none
module eavr_horner_cell import eavr_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic signed [ACC_W-1:0] coef,
    input  wire logic signed [ACC_W-1:0] acc_in,
    input  wire logic [U_W-1:0]          u_in,
    input  wire logic [U_W-1:0]          u2_in,
    input  wire lane_flags_t             fl_in,
    output logic signed [ACC_W-1:0]      acc_reg,
    output logic [U_W-1:0]               u_reg,
    output logic [U_W-1:0]               u2_reg,
    output lane_flags_t                  fl_reg
);
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = ACC_W'(mul_round30(acc_in, u2_in) + (ACC_W+1)'(coef));

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
            u_reg   <= u_in;
            u2_reg  <= u2_in;
            fl_reg  <= fl_in;
        end
    end
endmodule
`default_nettype wire

[rtl/core/eavr_sine_lane.sv]
// Pipelined sine (or cosine) of one binary angle, Q(TFB) signed result.
// Depends on eavr_pkg and eavr_horner_cell.
`default_nettype none
module eavr_sine_lane import eavr_pkg::*; #(
    parameter int TFB    = 15,
    parameter bit IS_COS = 1'b0
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [ANGLE_W-1:0]      angle,
    output logic signed [TFB+1:0]        trig_reg
);
    localparam int TW = TFB + 2;
    localparam int SH = 30 - TFB;
    localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);

    logic [ANGLE_W-1:0] a2;
    logic [U_W-1:0]     u0, u_s0;
    logic [2*U_W-1:0]   usq;
    logic [2*U_W-1:0]   u2_full;

    logic [U_W-1:0]     u0_reg, u1_reg, u2_1_reg;
    lane_flags_t        fl0_reg, fl1_reg, fl7_reg;
    lane_flags_t        fl_s0;
    logic signed [ACC_W:0] acc7_reg;

    logic signed [ACC_W-1:0] acc_c [HORNER_STAGES+1];
    logic [U_W-1:0]          u_c   [HORNER_STAGES+1];
    logic [U_W-1:0]          u2_c  [HORNER_STAGES+1];
    lane_flags_t             fl_c  [HORNER_STAGES+1];

    logic [U_W-1:0]  mag;
    logic [U_W+1:0]  rnd;
    logic [TW-1:0]   tmag;

    assign a2   = angle + (IS_COS ? QUARTER : '0);
    assign u0   = U_W'(a2[ANGLE_W-3:0]) << (32 - ANGLE_W);
    assign u_s0 = a2[ANGLE_W-2] ? (Q30_ONE - u0) : u0;
    assign fl_s0.neg  = a2[ANGLE_W-1];
    assign fl_s0.one  = (u_s0 >= Q30_ONE);
    assign fl_s0.zero = (u_s0 == '0);

    assign usq     = (2*U_W)'(u0_reg) * (2*U_W)'(u0_reg);
    assign u2_full = (usq + ((2*U_W)'(1) << 29)) >> 30;

    always_ff @(posedge aclk) begin
        if (en) begin
            u0_reg   <= u_s0;
            fl0_reg  <= fl_s0;
            u1_reg   <= u0_reg;
            u2_1_reg <= u2_full[U_W-1:0];
            fl1_reg  <= fl0_reg;
        end
    end

    assign acc_c[0] = -SIN_C11;
    assign u_c[0]   = u1_reg;
    assign u2_c[0]  = u2_1_reg;
    assign fl_c[0]  = fl1_reg;

    for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_cell
        eavr_horner_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .coef    (HORNER_COEF[k]),
            .acc_in  (acc_c[k]),
            .u_in    (u_c[k]),
            .u2_in   (u2_c[k]),
            .fl_in   (fl_c[k]),
            .acc_reg (acc_c[k+1]),
            .u_reg   (u_c[k+1]),
            .u2_reg  (u2_c[k+1]),
            .fl_reg  (fl_c[k+1])
        );
    end

    always_comb begin
        if (fl7_reg.one) begin
            mag = Q30_ONE;
        end else if (fl7_reg.zero || acc7_reg < 0) begin
            mag = '0;
        end else if (acc7_reg > $signed({2'b00, Q30_ONE})) begin
            mag = Q30_ONE;
        end else begin
            mag = acc7_reg[U_W-1:0];
        end
    end

    assign rnd  = (({2'b00, mag} << 1) + ((U_W+2)'(1) << SH)) >> (SH + 1);
    assign tmag = rnd[TW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            acc7_reg <= mul_round30(acc_c[HORNER_STAGES], u_c[HORNER_STAGES]);
            fl7_reg  <= fl_c[HORNER_STAGES];
            trig_reg <= fl7_reg.neg ? -$signed(tmag) : $signed(tmag);
        end
    end
endmodule
`default_nettype wire

[rtl/core/eavr_dot_row.sv]
// One output component: matrix row times vector, round, saturate.
// Depends on eavr_pkg; the products and the result are registered.
`default_nettype none
module eavr_dot_row import eavr_pkg::*; #(
    parameter int TFB = 15
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [TFB+1:0]     e [3],
    input  wire logic signed [COORD_W-1:0] v [3],
    output logic signed [COORD_W-1:0]      rot_reg,
    output logic                           sat_reg
);
    localparam int TW    = TFB + 2;
    localparam int PH_W  = TW + COORD_W;
    localparam int PL_W  = TW + TFB + 1;
    localparam int SH_W  = PH_W + 2;
    localparam int SL_W  = PL_W + 3;
    localparam int RES_W = SH_W + 1;

    logic signed [PH_W-1:0] ph_reg [3];
    logic signed [PL_W-1:0] pl_reg [3];
    logic signed [SH_W-1:0] shi;
    logic signed [SL_W-1:0] slo;
    logic signed [RES_W-1:0] res;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                ph_reg[j] <= PH_W'(e[j]) * PH_W'(v[j] >>> TFB);
                pl_reg[j] <= PL_W'(e[j]) * PL_W'($signed({1'b0, v[j][TFB-1:0]}));
            end
        end
    end

    assign shi = SH_W'(ph_reg[0]) + SH_W'(ph_reg[1]) + SH_W'(ph_reg[2]);
    assign slo = SL_W'(pl_reg[0]) + SL_W'(pl_reg[1]) + SL_W'(pl_reg[2])
               + (SL_W'(1) << (TFB - 1));
    assign res = RES_W'(shi) + RES_W'(slo >>> TFB);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (res > RES_W'(COORD_MAX)) begin
                rot_reg <= COORD_MAX;
                sat_reg <= 1'b1;
            end else if (res < RES_W'(COORD_MIN)) begin
                rot_reg <= COORD_MIN;
                sat_reg <= 1'b1;
            end else begin
                rot_reg <= res[COORD_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[dv/tb_euler_angle_vector_rotation_top.sv]
// Self-checking testbench for the Euler angle vector rotation core.
// Depends on eavr_pkg and euler_angle_vector_rotation_top; predicts each result internally.
module tb_euler_angle_vector_rotation_top import eavr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIG_FRAC = 15;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint QONE = 64'sd1073741824;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    eavr_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    eavr_out_t m_data;

    eavr_in_t  pending_q[$];
    eavr_out_t rotated_q[$];
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    bit        hold_toggle = 1'b0;
    bit        hold_seen = 1'b0;
    int        hold_left = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    euler_angle_vector_rotation_top #(.TRIG_FRAC_BITS(TRIG_FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint rnd_mul(longint a, longint b, int sh);
        bit neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p = (ma * mb + ((64'd1 << sh) >> 1)) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint quarter_sin_q30(longint u);
        longint u2, acc;
        if (u >= QONE) return QONE;
        if (u <= 0) return 0;
        u2 = rnd_mul(u, u, 30);
        acc = -64'sd3864;
        acc = 64'sd172272 + rnd_mul(acc, u2, 30);
        acc = -64'sd5026995 + rnd_mul(acc, u2, 30);
        acc = 64'sd85569306 + rnd_mul(acc, u2, 30);
        acc = -64'sd693598668 + rnd_mul(acc, u2, 30);
        acc = 64'sd1686629713 + rnd_mul(acc, u2, 30);
        acc = rnd_mul(acc, u, 30);
        if (acc < 0) acc = 0;
        if (acc > QONE) acc = QONE;
        return acc;
    endfunction

    function automatic longint sin_bam(logic [ANGLE_W-1:0] a);
        logic [1:0] quad;
        longint u, mag;
        quad = a[ANGLE_W-1 -: 2];
        u = longint'(a[ANGLE_W-3:0]) << (32 - ANGLE_W);
        if (quad[0]) u = QONE - u;
        mag = quarter_sin_q30(u);
        mag = (mag + ((64'sd1 << (30 - TRIG_FRAC)) >> 1)) >>> (30 - TRIG_FRAC);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint cos_bam(logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] b;
        b = a + (ANGLE_W'(1) << (ANGLE_W - 2));
        return sin_bam(b);
    endfunction

    function automatic longint tmul(longint a, longint b);
        return rnd_mul(a, b, TRIG_FRAC);
    endfunction

    function automatic longint clip_unit(longint e);
        longint one;
        one = 64'sd1 << TRIG_FRAC;
        if (e > one) return one;
        if (e < -one) return -one;
        return e;
    endfunction

    function automatic eavr_out_t rotate_vector(eavr_in_t t);
        eavr_out_t r;
        longint v[3], m[3][3], row[3], res[3];
        longint sph, cph, st, ct, sps, cps, st_cps, st_sps, shi, slo;
        longint maxv, minv;
        bit sat;
        maxv = (64'sd1 <<< (COORD_W - 1)) - 1;
        minv = -maxv - 1;
        sat = 1'b0;
        v[0] = t.vec_x;
        v[1] = t.vec_y;
        v[2] = t.vec_z;
        sph = sin_bam(t.roll);
        cph = cos_bam(t.roll);
        st = sin_bam(t.pitch);
        ct = cos_bam(t.pitch);
        sps = sin_bam(t.yaw);
        cps = cos_bam(t.yaw);
        st_cps = tmul(st, cps);
        st_sps = tmul(st, sps);
        m[0][0] = tmul(ct, cps);
        m[0][1] = tmul(ct, sps);
        m[0][2] = -st;
        m[1][0] = clip_unit(tmul(sph, st_cps) - tmul(cph, sps));
        m[1][1] = clip_unit(tmul(sph, st_sps) + tmul(cph, cps));
        m[1][2] = tmul(sph, ct);
        m[2][0] = clip_unit(tmul(cph, st_cps) + tmul(sph, sps));
        m[2][1] = clip_unit(tmul(cph, st_sps) - tmul(sph, cps));
        m[2][2] = tmul(cph, ct);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                row[j] = t.req_type ? m[j][i] : m[i][j];
            shi = 0;
            slo = 0;
            for (int j = 0; j < 3; j++) begin
                shi += row[j] * (v[j] >>> TRIG_FRAC);
                slo += row[j] * (v[j] & ((64'sd1 << TRIG_FRAC) - 1));
            end
            slo += 64'sd1 << (TRIG_FRAC - 1);
            res[i] = shi + (slo >>> TRIG_FRAC);
            if (res[i] > maxv) begin
                res[i] = maxv;
                sat = 1'b1;
            end else if (res[i] < minv) begin
                res[i] = minv;
                sat = 1'b1;
            end
        end
        r.rot_x = res[0][COORD_W-1:0];
        r.rot_y = res[1][COORD_W-1:0];
        r.rot_z = res[2][COORD_W-1:0];
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return ANGLE_W'($urandom_range(0, 3)) << (ANGLE_W - 2);
            1: return ANGLE_W'(1) << (ANGLE_W - 1);
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    task automatic add_item(logic rt, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic [ANGLE_W-1:0] r,
                            logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] w);
        eavr_in_t t;
        t.req_type = rt;
        t.vec_x = x;
        t.vec_y = y;
        t.vec_z = z;
        t.roll = r;
        t.pitch = p;
        t.yaw = w;
        pending_q.push_back(t);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            add_item($urandom_range(0, 1), pick_coord(), pick_coord(), pick_coord(),
                     pick_angle(), pick_angle(), pick_angle());
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || s_valid || rotated_q.size() != 0)
            @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                s_data <= pending_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, predictor and checker
    always @(posedge aclk) begin
        eavr_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                rotated_q.push_back(rotate_vector(s_data));
            if (m_valid && m_ready) begin
                if (rotated_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", m_data);
                end else begin
                    want = rotated_q.pop_front();
                    if (want.rot_x !== m_data.rot_x || want.rot_y !== m_data.rot_y ||
                        want.rot_z !== m_data.rot_z || want.saturated !== m_data.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp x=%h y=%h z=%h sat=%b ",
                                      "got x=%h y=%h z=%h sat=%b"},
                                     want.rot_x, want.rot_y, want.rot_z, want.saturated,
                                     m_data.rot_x, m_data.rot_y, m_data.rot_z,
                                     m_data.saturated);
                    end
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: angle extremes, both directions, coordinate extremes, overflow
        add_item(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(1'b0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h0000, 16'h0000);
        add_item(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h4000, 16'h0000);
        add_item(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h0000, 16'h4000);
        add_item(1'b0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 16'h8000, 16'h8000, 16'h8000);
        add_item(1'b1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 16'h7FFF, 16'hFFFF, 16'hC000);
        add_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
        add_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h2000, 16'hE000, 16'h2000);
        add_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h7FFF, 16'h8000, 16'h0001);
        add_item(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 16'h3FFF);
        add_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hC001, 16'h4001, 16'hBFFF);
        add_item(1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF, 16'h1000, 16'h9000, 16'h6000);
        add_item(1'b1, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF, 16'h1000, 16'h9000, 16'h6000);
        add_item(1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        sender_idle_pct = 27;
        receiver_idle_pct = 53;
        add_random(360);
        drain();

        sender_idle_pct = 53;
        receiver_idle_pct = 27;
        add_random(360);
        drain();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_toggle = ~hold_toggle;
        add_random(370);
        drain();

        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[euler_angle_vector_rotation_top.f]
+incdir+rtl/core
rtl/core/eavr_pkg.sv
rtl/core/eavr_horner_cell.sv
rtl/core/eavr_sine_lane.sv
rtl/core/eavr_dot_row.sv
rtl/core/euler_angle_vector_rotation_top.sv
dv/tb_euler_angle_vector_rotation_top.sv
